@@ sv/ppp_pkg.sv @@
`default_nettype none

package ppp_pkg;

   localparam int FRAC_BITS_DEF     = 16;
   localparam int CORDIC_STAGES_DEF = 20;
   localparam int ATAN_ENTRIES      = 30;
   localparam int DATA_W            = 32;
   localparam int ROOT_BITS         = 32;
   localparam int CX_W              = 36;   // CORDIC x/y, covers folding and gain growth
   localparam int Z_W               = 35;   // CORDIC angle, Q30

   localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;

   typedef enum logic [2:0] {
      CSR_PLANE_SELECT   = 3'd0,
      CSR_DIRECTION_GAIN = 3'd1,
      CSR_LENGTH_GAIN    = 3'd2,
      CSR_HEIGHT_GAIN    = 3'd3,
      CSR_HEIGHT_BIAS    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   localparam logic [2:0] PLANE_XY = 3'd0;
   localparam logic [2:0] PLANE_YX = 3'd1;
   localparam logic [2:0] PLANE_YZ = 3'd2;
   localparam logic [2:0] PLANE_ZY = 3'd3;
   localparam logic [2:0] PLANE_ZX = 3'd4;
   localparam logic [2:0] PLANE_XZ = 3'd5;

   function automatic logic plane_ok(input logic [2:0] sel);
      return sel <= PLANE_XZ;
   endfunction

   function automatic axis_type first_axis(input logic [2:0] sel);
      axis_type a;
      case (sel)
         PLANE_XY: a = AXIS_X;
         PLANE_YX: a = AXIS_Y;
         PLANE_YZ: a = AXIS_Y;
         PLANE_ZY: a = AXIS_Z;
         PLANE_ZX: a = AXIS_Z;
         PLANE_XZ: a = AXIS_X;
         default:  a = AXIS_X;
      endcase
      return a;
   endfunction

   function automatic axis_type second_axis(input logic [2:0] sel);
      axis_type a;
      case (sel)
         PLANE_XY: a = AXIS_Y;
         PLANE_YX: a = AXIS_X;
         PLANE_YZ: a = AXIS_Z;
         PLANE_ZY: a = AXIS_Y;
         PLANE_ZX: a = AXIS_X;
         PLANE_XZ: a = AXIS_Z;
         default:  a = AXIS_Y;
      endcase
      return a;
   endfunction

   function automatic axis_type normal_axis(input logic [2:0] sel);
      axis_type a;
      case (sel)
         PLANE_XY: a = AXIS_Z;
         PLANE_YX: a = AXIS_Z;
         PLANE_YZ: a = AXIS_X;
         PLANE_ZY: a = AXIS_X;
         PLANE_ZX: a = AXIS_Y;
         PLANE_XZ: a = AXIS_Y;
         default:  a = AXIS_Z;
      endcase
      return a;
   endfunction

   // reversed pairs flip the height
   function automatic logic normal_neg(input logic [2:0] sel);
      logic n;
      case (sel)
         PLANE_YX: n = 1'b1;
         PLANE_ZY: n = 1'b1;
         PLANE_XZ: n = 1'b1;
         default:  n = 1'b0;
      endcase
      return n;
   endfunction

   function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [Z_W-1:0] a;
      case (idx)
         5'd0:    a = 35'sd843314857;
         5'd1:    a = 35'sd497837829;
         5'd2:    a = 35'sd263043837;
         5'd3:    a = 35'sd133525159;
         5'd4:    a = 35'sd67021687;
         5'd5:    a = 35'sd33543516;
         5'd6:    a = 35'sd16775851;
         5'd7:    a = 35'sd8388437;
         5'd8:    a = 35'sd4194283;
         5'd9:    a = 35'sd2097149;
         5'd10:   a = 35'sd1048576;
         5'd11:   a = 35'sd524288;
         5'd12:   a = 35'sd262144;
         5'd13:   a = 35'sd131072;
         5'd14:   a = 35'sd65536;
         5'd15:   a = 35'sd32768;
         5'd16:   a = 35'sd16384;
         5'd17:   a = 35'sd8192;
         5'd18:   a = 35'sd4096;
         5'd19:   a = 35'sd2048;
         5'd20:   a = 35'sd1024;
         5'd21:   a = 35'sd512;
         5'd22:   a = 35'sd256;
         5'd23:   a = 35'sd128;
         5'd24:   a = 35'sd64;
         5'd25:   a = 35'sd32;
         5'd26:   a = 35'sd16;
         5'd27:   a = 35'sd8;
         5'd28:   a = 35'sd4;
         5'd29:   a = 35'sd2;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

@@ sv/ppp_div_pipe.sv @@
`default_nettype none

// Restoring divider, one quotient bit per stage, MSB first.
// Caller guarantees the quotient fits FRAC_BITS+1 bits.
module ppp_div_pipe import ppp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic [FRAC_BITS:0]          en,
   input  logic [DATA_W+FRAC_BITS:0]   rem_in,
   input  logic [DATA_W-1:0]           den_in,
   output logic [FRAC_BITS:0]          quo_out
);

   localparam int DW = DATA_W + FRAC_BITS + 1;
   localparam int NQ = FRAC_BITS + 1;

   logic [DW-1:0]     rem_ff [NQ];
   logic [DATA_W-1:0] den_ff [NQ];
   logic [NQ-1:0]     quo_ff [NQ];

   for (genvar j = 0; j < NQ; j++) begin : g_bit
      localparam int B = FRAC_BITS - j;
      logic [DW-1:0]     rem_p;
      logic [DATA_W-1:0] den_p;
      logic [NQ-1:0]     quo_p;
      logic [DW-1:0]     sub;
      logic              fit;

      if (j == 0) begin : g_first
         assign rem_p = rem_in;
         assign den_p = den_in;
         assign quo_p = '0;
      end else begin : g_next
         assign rem_p = rem_ff[j-1];
         assign den_p = den_ff[j-1];
         assign quo_p = quo_ff[j-1];
      end

      assign sub = DW'(den_p) << B;
      assign fit = rem_p >= sub;

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j] <= fit ? rem_p - sub : rem_p;
            den_ff[j] <= den_p;
            quo_ff[j] <= fit ? (quo_p | (NQ'(1) << B)) : quo_p;
         end
      end
   end

   assign quo_out = quo_ff[NQ-1];

endmodule

`default_nettype wire

@@ sv/plane_projection_to_polar.sv @@
`default_nettype none

// Channel  | Ports                          | Moves
// req      | req_valid / req_ready          | in_x, in_y, in_z
// rsp      | rsp_valid / rsp_ready          | dir_x/y/z, length, height, phase, bad_plane
// csr      | csr_valid / csr_ready          | csr_index, csr_data (register write)
//
// One transaction per cycle sustained while rsp_ready stays high. The pipeline has FRAC_BITS+39
// register stages (55 at defaults), set by the 32-stage square root followed by the
// FRAC_BITS+1-stage dividers; CORDIC steps run alongside the root stages.
// Reset clears stage valid bits and loads register defaults; data is not reset.
// A stall holds only full stages with no bubble between them and the output; bubbles close up.
module plane_projection_to_polar import ppp_pkg::*; #(
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [DATA_W-1:0]   req_in_x,
   input  logic signed [DATA_W-1:0]   req_in_y,
   input  logic signed [DATA_W-1:0]   req_in_z,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_dir_x,
   output logic signed [DATA_W-1:0]   rsp_dir_y,
   output logic signed [DATA_W-1:0]   rsp_dir_z,
   output logic signed [DATA_W-1:0]   rsp_plane_length,
   output logic signed [DATA_W-1:0]   rsp_plane_height,
   output logic signed [FRAC_BITS+2:0] rsp_plane_phase,
   output logic                       rsp_bad_plane,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [2:0]                 csr_index,
   input  logic [DATA_W-1:0]          csr_data
);

   localparam int F   = FRAC_BITS;
   localparam int PW  = F + 3;
   localparam int CS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
   localparam int DW  = DATA_W + F + 1;
   localparam int PDW = F + 2 + DATA_W;
   localparam int PLW = 2 * DATA_W + 1;
   localparam int RW  = 68;
   localparam int PH_S = 30 - F;

   localparam int ST_SQ    = 1;
   localparam int ST_SUM   = 2;
   localparam int ST_ROOT0 = 3;
   localparam int ST_DSET  = ST_ROOT0 + ROOT_BITS;
   localparam int ST_DIV0  = ST_DSET + 1;
   localparam int ST_MUL   = ST_DIV0 + F + 1;
   localparam int ST_OUT   = ST_MUL + 1;
   localparam int NS       = ST_OUT + 1;

   localparam logic signed [Z_W:0] PH_HALF = (Z_W+1)'(64'sd1 <<< (PH_S - 1));
   localparam logic signed [Z_W:0] PH_LIM  =
      ($signed({PI_Q30[Z_W-1], PI_Q30}) + PH_HALF) >>> PH_S;
   localparam logic signed [PW-1:0] PH_LIM_P = PW'(PH_LIM);
   localparam logic signed [RW-1:0] RND_HALF = RW'(64'sd1 <<< (F - 1));
   localparam logic signed [RW-1:0] SAT_MAX  = RW'(64'sd2147483647);
   localparam logic signed [RW-1:0] SAT_MIN  = -RW'(64'sd2147483648);

   function automatic logic signed [DATA_W-1:0] pick(input axis_type a,
         input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
         input logic signed [DATA_W-1:0] z);
      logic signed [DATA_W-1:0] r;
      case (a)
         AXIS_X:  r = x;
         AXIS_Y:  r = y;
         AXIS_Z:  r = z;
         default: r = x;
      endcase
      return r;
   endfunction

   function automatic logic signed [RW-1:0] round_q(input logic signed [RW-1:0] p);
      return (p + RND_HALF) >>> F;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [RW-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_MAX) r = SAT_MAX[DATA_W-1:0];
      else if (v < SAT_MIN) r = SAT_MIN[DATA_W-1:0];
      else r = v[DATA_W-1:0];
      return r;
   endfunction

   // ---------------- configuration ----------------
   logic [2:0]               plane_sel_ff;
   logic signed [DATA_W-1:0] dir_gain_ff;
   logic signed [DATA_W-1:0] len_gain_ff;
   logic signed [DATA_W-1:0] hgt_gain_ff;
   logic signed [DATA_W-1:0] hgt_bias_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_sel_ff <= PLANE_XY;
         dir_gain_ff  <= 32'sd65536;
         len_gain_ff  <= 32'sd65536;
         hgt_gain_ff  <= 32'sd65536;
         hgt_bias_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PLANE_SELECT:   plane_sel_ff <= csr_data[2:0];
            CSR_DIRECTION_GAIN: dir_gain_ff  <= csr_data;
            CSR_LENGTH_GAIN:    len_gain_ff  <= csr_data;
            CSR_HEIGHT_GAIN:    hgt_gain_ff  <= csr_data;
            CSR_HEIGHT_BIAS:    hgt_bias_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- stage control ----------------
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= req_valid;
         for (int i = 1; i < NS; i++) begin
            if (en[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign req_ready = en[0];

   // ---------------- stage 0: axis selection ----------------
   logic signed [DATA_W-1:0] u_in, v_in, n_in;
   logic signed [DATA_W:0]   h_in;
   logic signed [DATA_W-1:0] u0_ff, v0_ff;
   logic signed [DATA_W:0]   h0_ff;

   always_comb begin
      u_in = pick(first_axis(plane_sel_ff), req_in_x, req_in_y, req_in_z);
      v_in = pick(second_axis(plane_sel_ff), req_in_x, req_in_y, req_in_z);
      n_in = pick(normal_axis(plane_sel_ff), req_in_x, req_in_y, req_in_z);
      h_in = normal_neg(plane_sel_ff) ? -(DATA_W+1)'(n_in) : (DATA_W+1)'(n_in);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u0_ff <= u_in;
         v0_ff <= v_in;
         h0_ff <= h_in;
      end
   end

   // ---------------- stage 1: squares, CORDIC fold ----------------
   logic [DATA_W-1:0]        au0, av0;
   logic [2*DATA_W-1:0]      squ_ff, sqv_ff;
   logic signed [DATA_W-1:0] u1_ff, v1_ff;
   logic signed [DATA_W:0]   h1_ff;
   logic signed [CX_W-1:0]   x_fold, y_fold, x1_ff, y1_ff;
   logic signed [Z_W-1:0]    z_fold, z1_ff;

   always_comb begin
      au0 = u0_ff[DATA_W-1] ? DATA_W'(-u0_ff) : DATA_W'(u0_ff);
      av0 = v0_ff[DATA_W-1] ? DATA_W'(-v0_ff) : DATA_W'(v0_ff);
      x_fold = CX_W'(u0_ff);
      y_fold = CX_W'(v0_ff);
      z_fold = '0;
      if (u0_ff[DATA_W-1]) begin
         x_fold = -CX_W'(u0_ff);
         y_fold = -CX_W'(v0_ff);
         z_fold = v0_ff[DATA_W-1] ? -PI_Q30 : PI_Q30;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SQ]) begin
         squ_ff <= au0 * au0;
         sqv_ff <= av0 * av0;
         u1_ff  <= u0_ff;
         v1_ff  <= v0_ff;
         h1_ff  <= h0_ff;
         x1_ff  <= x_fold;
         y1_ff  <= y_fold;
         z1_ff  <= z_fold;
      end
   end

   // ---------------- stage 2: sum of squares ----------------
   logic [2*DATA_W-1:0]      sum_ff;
   logic signed [DATA_W-1:0] u2_ff, v2_ff;
   logic signed [DATA_W:0]   h2_ff;
   logic signed [CX_W-1:0]   x2_ff, y2_ff;
   logic signed [Z_W-1:0]    z2_ff;

   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         sum_ff <= squ_ff + sqv_ff;
         u2_ff  <= u1_ff;
         v2_ff  <= v1_ff;
         h2_ff  <= h1_ff;
         x2_ff  <= x1_ff;
         y2_ff  <= y1_ff;
         z2_ff  <= z1_ff;
      end
   end

   // ---------------- root stages with CORDIC alongside ----------------
   logic [2*DATA_W-1:0]      rrem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0]     rroot_ff [ROOT_BITS];
   logic signed [DATA_W-1:0] ru_ff    [ROOT_BITS];
   logic signed [DATA_W-1:0] rv_ff    [ROOT_BITS];
   logic signed [DATA_W:0]   rh_ff    [ROOT_BITS];
   logic signed [CX_W-1:0]   rx_ff    [ROOT_BITS];
   logic signed [CX_W-1:0]   ry_ff    [ROOT_BITS];
   logic signed [Z_W-1:0]    rz_ff    [ROOT_BITS];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
      localparam int B = ROOT_BITS - 1 - k;
      logic [2*DATA_W-1:0]      rem_p;
      logic [ROOT_BITS-1:0]     root_p;
      logic signed [DATA_W-1:0] u_p, v_p;
      logic signed [DATA_W:0]   h_p;
      logic signed [CX_W-1:0]   x_p, y_p, x_n, y_n;
      logic signed [Z_W-1:0]    z_p, z_n;
      logic [2*DATA_W:0]        trial;
      logic                     fit;

      if (k == 0) begin : g_first
         assign rem_p  = sum_ff;
         assign root_p = '0;
         assign u_p    = u2_ff;
         assign v_p    = v2_ff;
         assign h_p    = h2_ff;
         assign x_p    = x2_ff;
         assign y_p    = y2_ff;
         assign z_p    = z2_ff;
      end else begin : g_next
         assign rem_p  = rrem_ff[k-1];
         assign root_p = rroot_ff[k-1];
         assign u_p    = ru_ff[k-1];
         assign v_p    = rv_ff[k-1];
         assign h_p    = rh_ff[k-1];
         assign x_p    = rx_ff[k-1];
         assign y_p    = ry_ff[k-1];
         assign z_p    = rz_ff[k-1];
      end

      // (root + 2^B)^2 - root^2
      assign trial = ((2*DATA_W+1)'(root_p) << (B + 1)) + ((2*DATA_W+1)'(1) << (2 * B));
      assign fit   = (2*DATA_W+1)'(rem_p) >= trial;

      if (k < CS) begin : g_rot
         always_comb begin
            if (!y_p[CX_W-1]) begin
               x_n = x_p + (y_p >>> k);
               y_n = y_p - (x_p >>> k);
               z_n = z_p + atan_q30(5'(k));
            end else begin
               x_n = x_p - (y_p >>> k);
               y_n = y_p + (x_p >>> k);
               z_n = z_p - atan_q30(5'(k));
            end
         end
      end else begin : g_hold
         assign x_n = x_p;
         assign y_n = y_p;
         assign z_n = z_p;
      end

      always_ff @(posedge clock) begin
         if (en[ST_ROOT0+k]) begin
            rrem_ff[k]  <= fit ? rem_p - trial[2*DATA_W-1:0] : rem_p;
            rroot_ff[k] <= fit ? (root_p | (ROOT_BITS'(1) << B)) : root_p;
            ru_ff[k]    <= u_p;
            rv_ff[k]    <= v_p;
            rh_ff[k]    <= h_p;
            rx_ff[k]    <= x_n;
            ry_ff[k]    <= y_n;
            rz_ff[k]    <= z_n;
         end
      end
   end

   // ---------------- divider setup, phase rounding ----------------
   logic [ROOT_BITS-1:0]     len_r;
   logic signed [DATA_W-1:0] u_r, v_r;
   logic [DATA_W-1:0]        au_r, av_r;
   logic signed [Z_W:0]      ph_round;
   logic signed [Z_W:0]      ph_clamp;
   logic [DW-1:0]            dremu_ff, dremv_ff;
   logic [ROOT_BITS-1:0]     dlen_ff;
   logic                     dsu_ff, dsv_ff;
   logic signed [DATA_W:0]   dh_ff;
   logic signed [PW-1:0]     dph_ff;

   always_comb begin
      len_r = rroot_ff[ROOT_BITS-1];
      u_r   = ru_ff[ROOT_BITS-1];
      v_r   = rv_ff[ROOT_BITS-1];
      au_r  = u_r[DATA_W-1] ? DATA_W'(-u_r) : DATA_W'(u_r);
      av_r  = v_r[DATA_W-1] ? DATA_W'(-v_r) : DATA_W'(v_r);
      ph_round = ((Z_W+1)'(rz_ff[ROOT_BITS-1]) + PH_HALF) >>> PH_S;
      if (len_r == '0) ph_clamp = '0;              // zero vector in plane
      else if (ph_round > PH_LIM) ph_clamp = PH_LIM;
      else if (ph_round < -PH_LIM) ph_clamp = -PH_LIM;
      else ph_clamp = ph_round;
   end

   always_ff @(posedge clock) begin
      if (en[ST_DSET]) begin
         dremu_ff <= (DW'(au_r) << F) + DW'(len_r >> 1);
         dremv_ff <= (DW'(av_r) << F) + DW'(len_r >> 1);
         dlen_ff  <= len_r;
         dsu_ff   <= u_r[DATA_W-1];
         dsv_ff   <= v_r[DATA_W-1];
         dh_ff    <= rh_ff[ROOT_BITS-1];
         dph_ff   <= PW'(ph_clamp);
      end
   end

   // ---------------- dividers and sideband ----------------
   logic [F:0] quo_u, quo_v;

   ppp_div_pipe #(.FRAC_BITS(F)) u_div_u (
      .clock   (clock),
      .en      (en[ST_DIV0 +: F+1]),
      .rem_in  (dremu_ff),
      .den_in  (dlen_ff),
      .quo_out (quo_u)
   );

   ppp_div_pipe #(.FRAC_BITS(F)) u_div_v (
      .clock   (clock),
      .en      (en[ST_DIV0 +: F+1]),
      .rem_in  (dremv_ff),
      .den_in  (dlen_ff),
      .quo_out (quo_v)
   );

   logic [ROOT_BITS-1:0]   sb_len_ff [F+1];
   logic                   sb_su_ff  [F+1];
   logic                   sb_sv_ff  [F+1];
   logic signed [DATA_W:0] sb_h_ff   [F+1];
   logic signed [PW-1:0]   sb_ph_ff  [F+1];

   always_ff @(posedge clock) begin
      if (en[ST_DIV0]) begin
         sb_len_ff[0] <= dlen_ff;
         sb_su_ff[0]  <= dsu_ff;
         sb_sv_ff[0]  <= dsv_ff;
         sb_h_ff[0]   <= dh_ff;
         sb_ph_ff[0]  <= dph_ff;
      end
      for (int j = 1; j <= F; j++) begin
         if (en[ST_DIV0+j]) begin
            sb_len_ff[j] <= sb_len_ff[j-1];
            sb_su_ff[j]  <= sb_su_ff[j-1];
            sb_sv_ff[j]  <= sb_sv_ff[j-1];
            sb_h_ff[j]   <= sb_h_ff[j-1];
            sb_ph_ff[j]  <= sb_ph_ff[j-1];
         end
      end
   end

   // ---------------- gain multiply ----------------
   logic signed [F+1:0]    qs_u, qs_v;
   logic signed [PDW-1:0]  mdu_ff, mdv_ff;
   logic signed [PLW-1:0]  mlen_ff, mh_ff;
   logic                   mzero_ff;
   logic signed [PW-1:0]   mph_ff;

   always_comb begin
      qs_u = sb_su_ff[F] ? -$signed({1'b0, quo_u}) : $signed({1'b0, quo_u});
      qs_v = sb_sv_ff[F] ? -$signed({1'b0, quo_v}) : $signed({1'b0, quo_v});
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         mdu_ff   <= qs_u * dir_gain_ff;
         mdv_ff   <= qs_v * dir_gain_ff;
         mlen_ff  <= $signed({1'b0, sb_len_ff[F]}) * len_gain_ff;
         mh_ff    <= sb_h_ff[F] * hgt_gain_ff;
         mzero_ff <= sb_len_ff[F] == '0;
         mph_ff   <= sb_ph_ff[F];
      end
   end

   // ---------------- round, saturate, place ----------------
   logic signed [DATA_W-1:0] du_s, dv_s, len_s, h_s;
   logic signed [DATA_W-1:0] dir_x_in, dir_y_in, dir_z_in;
   logic                     bad_in;
   axis_type                 ax_u, ax_v;
   logic signed [DATA_W-1:0] dir_x_ff, dir_y_ff, dir_z_ff, len_ff, hgt_ff;
   logic signed [PW-1:0]     ph_ff;
   logic                     bad_ff;

   always_comb begin
      bad_in = !plane_ok(plane_sel_ff);
      ax_u   = first_axis(plane_sel_ff);
      ax_v   = second_axis(plane_sel_ff);
      du_s   = sat32(round_q(RW'(mdu_ff)));
      dv_s   = sat32(round_q(RW'(mdv_ff)));
      len_s  = sat32(round_q(RW'(mlen_ff)));
      h_s    = sat32(round_q(RW'(mh_ff)) + RW'(hgt_bias_ff));
      dir_x_in = '0;
      dir_y_in = '0;
      dir_z_in = '0;
      if (!mzero_ff) begin
         case (ax_u)
            AXIS_X:  dir_x_in = du_s;
            AXIS_Y:  dir_y_in = du_s;
            AXIS_Z:  dir_z_in = du_s;
            default: ;
         endcase
         case (ax_v)
            AXIS_X:  dir_x_in = dv_s;
            AXIS_Y:  dir_y_in = dv_s;
            AXIS_Z:  dir_z_in = dv_s;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         bad_ff   <= bad_in;
         dir_x_ff <= bad_in ? '0 : dir_x_in;
         dir_y_ff <= bad_in ? '0 : dir_y_in;
         dir_z_ff <= bad_in ? '0 : dir_z_in;
         len_ff   <= bad_in ? '0 : len_s;
         hgt_ff   <= bad_in ? '0 : h_s;
         ph_ff    <= bad_in ? '0 : mph_ff;
      end
   end

   assign rsp_valid        = valid_ff[NS-1];
   assign rsp_dir_x        = dir_x_ff;
   assign rsp_dir_y        = dir_y_ff;
   assign rsp_dir_z        = dir_z_ff;
   assign rsp_plane_length = len_ff;
   assign rsp_plane_height = hgt_ff;
   assign rsp_plane_phase  = ph_ff;
   assign rsp_bad_plane    = bad_ff;

   // ---------------- assertions ----------------
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_plane |-> rsp_dir_x == '0 && rsp_dir_y == '0 &&
         rsp_dir_z == '0 && rsp_plane_length == '0 && rsp_plane_height == '0 &&
         rsp_plane_phase == '0)
      else $error("bad plane result carries nonzero fields");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_plane_phase <= PH_LIM_P && rsp_plane_phase >= -PH_LIM_P)
      else $error("phase outside +-pi");

   a_bubble_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[0] |-> req_ready)
      else $error("input stage empty but not ready");

   a_len_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_plane && !len_gain_ff[DATA_W-1] |-> !rsp_plane_length[DATA_W-1])
      else $error("negative length with nonnegative gain");

endmodule

`default_nettype wire

@@ tb/projection_checker.sv @@
`default_nettype none

module projection_checker import ppp_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic signed [31:0]       req_in_x,
   input  wire logic signed [31:0]       req_in_y,
   input  wire logic signed [31:0]       req_in_z,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic signed [31:0]       rsp_dir_x,
   input  wire logic signed [31:0]       rsp_dir_y,
   input  wire logic signed [31:0]       rsp_dir_z,
   input  wire logic signed [31:0]       rsp_plane_length,
   input  wire logic signed [31:0]       rsp_plane_height,
   input  wire logic signed [18:0]       rsp_plane_phase,
   input  wire logic                     rsp_bad_plane,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [2:0]               csr_index,
   input  wire logic [31:0]              csr_data,
   output int                            error_count,
   output int                            pending_count,
   output int                            result_count
);

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int STAGES = CORDIC_STAGES_DEF;
   localparam longint PI_ANGLE = 64'sd3373259426;

   typedef struct {
      logic signed [31:0] dir [3];
      logic signed [31:0] length;
      logic signed [31:0] height;
      logic signed [18:0] phase;
      logic               bad;
   } projection_type;

   const longint arctan_q30 [30] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149,
      1048576, 524288, 262144, 131072, 65536,
      32768, 16384, 8192, 4096, 2048,
      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

   const axis_type u_axis [6] = '{AXIS_X, AXIS_Y, AXIS_Y, AXIS_Z, AXIS_Z, AXIS_X};
   const axis_type v_axis [6] = '{AXIS_Y, AXIS_X, AXIS_Z, AXIS_Y, AXIS_X, AXIS_Z};
   const axis_type h_axis [6] = '{AXIS_Z, AXIS_Z, AXIS_X, AXIS_X, AXIS_Y, AXIS_Y};
   const bit       h_flip [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

   logic [2:0]     plane_sel;
   longint         dir_gain, len_gain, hgt_gain, hgt_bias;
   projection_type expected_q [$];

   assign pending_count = expected_q.size();

   function automatic longint rnd_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // round half away from zero
   function automatic longint unit_part(longint c, longint unsigned len);
      longint unsigned m, q;
      m = longint'(c < 0 ? -c : c) << FRAC;
      q = (m + len / 2) / len;
      return c < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint vector_angle(longint u, longint v);
      longint x, y, z, nx, ny, p, lim;
      if (u == 0 && v == 0) return 0;
      x = u;
      y = v;
      z = 0;
      if (x < 0) begin
         z = (y < 0) ? -PI_ANGLE : PI_ANGLE;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STAGES && i < 30; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z  = z + arctan_q30[i];
         end else begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z  = z - arctan_q30[i];
         end
         x = nx;
         y = ny;
      end
      p = rnd_shift(z, 30 - FRAC);
      lim = rnd_shift(PI_ANGLE, 30 - FRAC);
      if (p > lim) p = lim;
      if (p < -lim) p = -lim;
      return p;
   endfunction

   function automatic projection_type project_vector(logic signed [31:0] ix,
                                                     logic signed [31:0] iy,
                                                     logic signed [31:0] iz);
      projection_type r;
      longint vec [3];
      longint u, v, h;
      longint unsigned au, av, len;
      int s;
      r.dir[0] = '0;
      r.dir[1] = '0;
      r.dir[2] = '0;
      r.length = '0;
      r.height = '0;
      r.phase  = '0;
      r.bad    = 1'b0;
      if (plane_sel > PLANE_XZ) begin
         r.bad = 1'b1;
         return r;
      end
      s = plane_sel;
      vec[0] = ix;
      vec[1] = iy;
      vec[2] = iz;
      u = vec[u_axis[s]];
      v = vec[v_axis[s]];
      h = h_flip[s] ? -vec[h_axis[s]] : vec[h_axis[s]];
      au = u < 0 ? -u : u;
      av = v < 0 ? -v : v;
      len = floor_root(au * au + av * av);
      if (len != 0) begin
         r.dir[u_axis[s]] = 32'(clip32(rnd_shift(unit_part(u, len) * dir_gain, FRAC)));
         r.dir[v_axis[s]] = 32'(clip32(rnd_shift(unit_part(v, len) * dir_gain, FRAC)));
      end
      r.length = 32'(clip32(rnd_shift(longint'(len) * len_gain, FRAC)));
      r.height = 32'(clip32(rnd_shift(h * hgt_gain, FRAC) + hgt_bias));
      r.phase  = 19'(vector_angle(u, v));
      return r;
   endfunction

   function automatic int compare_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      projection_type want;
      int bad;
      if (reset) begin
         plane_sel    <= PLANE_XY;
         dir_gain     <= 65536;
         len_gain     <= 65536;
         hgt_gain     <= 65536;
         hgt_bias     <= 0;
         error_count  <= 0;
         result_count <= 0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PLANE_SELECT:   plane_sel <= csr_data[2:0];
               CSR_DIRECTION_GAIN: dir_gain  <= longint'(signed'(csr_data));
               CSR_LENGTH_GAIN:    len_gain  <= longint'(signed'(csr_data));
               CSR_HEIGHT_GAIN:    hgt_gain  <= longint'(signed'(csr_data));
               CSR_HEIGHT_BIAS:    hgt_bias  <= longint'(signed'(csr_data));
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_q.push_back(project_vector(req_in_x, req_in_y, req_in_z));
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: result transaction with nothing expected", $time);
               error_count <= error_count + 1;
            end else begin
               want = expected_q.pop_front();
               bad = 0;
               bad += compare_field("dir_x", want.dir[0], rsp_dir_x);
               bad += compare_field("dir_y", want.dir[1], rsp_dir_y);
               bad += compare_field("dir_z", want.dir[2], rsp_dir_z);
               bad += compare_field("plane_length", want.length, rsp_plane_length);
               bad += compare_field("plane_height", want.height, rsp_plane_height);
               bad += compare_field("plane_phase", want.phase, rsp_plane_phase);
               bad += compare_field("bad_plane", want.bad, rsp_bad_plane);
               if (bad != 0) error_count <= error_count + 1;
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb import ppp_pkg::*;;

   localparam int IDLE_LIMIT = 6000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_in_x = '0, req_in_y = '0, req_in_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic signed [31:0] rsp_plane_length, rsp_plane_height;
   logic signed [18:0] rsp_plane_phase;
   logic rsp_bad_plane;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   int error_count, pending_count, result_count;
   int vectors_sent = 0;
   int csr_writes = 0;
   int burst_left = 0;
   int hold_requests = 0;
   int idle_cycles = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   plane_projection_to_polar uut (
      .clock, .reset,
      .req_valid, .req_ready, .req_in_x, .req_in_y, .req_in_z,
      .rsp_valid, .rsp_ready, .rsp_dir_x, .rsp_dir_y, .rsp_dir_z,
      .rsp_plane_length, .rsp_plane_height, .rsp_plane_phase, .rsp_bad_plane,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   projection_checker chk (
      .clock, .reset,
      .req_valid, .req_ready, .req_in_x, .req_in_y, .req_in_z,
      .rsp_valid, .rsp_ready, .rsp_dir_x, .rsp_dir_y, .rsp_dir_z,
      .rsp_plane_length, .rsp_plane_height, .rsp_plane_phase, .rsp_bad_plane,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .error_count, .pending_count, .result_count
   );

   // receiver: stall pattern changes mode every so often; a hold request
   // forces one long stretch of back-pressure
   always @(posedge clock) begin
      static int mode = 0, mode_left = 0, holds_seen = 0, hold_left = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (holds_seen != hold_requests) begin
            holds_seen = holds_seen + 1;
            hold_left = 400;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left = mode_left - 1;
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      bit taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_valid <= 1'b1;
      req_in_x <= x;
      req_in_y <= y;
      req_in_z <= z;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      vectors_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   // csr_valid stays up between back-to-back writes; the caller drops it
   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_writes++;
   endtask

   task automatic load_settings(logic [2:0] plane, logic [31:0] dg, logic [31:0] lg,
                                logic [31:0] hg, logic [31:0] hb);
      wait_drained();
      write_csr(CSR_PLANE_SELECT, {29'd0, plane});
      write_csr(CSR_DIRECTION_GAIN, dg);
      write_csr(CSR_LENGTH_GAIN, lg);
      write_csr(CSR_HEIGHT_GAIN, hg);
      write_csr(CSR_HEIGHT_BIAS, hb);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_component();
      case ($urandom_range(0, 6))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               default: return 32'hffff_ffff;
            endcase
         end
         3: return $urandom_range(0, 2048) - 1024;
         default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return 32'h0001_0000;
         1: return 32'hffff_0000;
         2: return 32'h7fff_ffff;
         3: return 32'h8000_0000;
         4: return 32'h0000_0000;
         5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] cx, cy, cz;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults after reset: plane XY, unit gains
      send_vector(32'h0, 32'h0, 32'h0);
      send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h8000_0000, 32'h0, 32'h1);
      send_vector(32'h0, 32'h8000_0000, 32'hffff_ffff);
      send_vector(32'h7fff_ffff, 32'h8000_0000, 32'h0);
      send_vector(32'hffff_fffb, 32'h0, 32'h0001_0000);   // fold onto +pi
      send_vector(32'hffff_fffb, 32'hffff_ffff, 32'h0);   // fold onto -pi
      send_vector(32'h0, 32'h0, 32'h8000_0000);           // zero in plane, nonzero height
      send_vector(32'h0001_0000, 32'h0, 32'h0);
      send_vector(32'h0, 32'hffff_0000, 32'h0);

      for (int p = PLANE_YX; p <= 7; p++) begin
         load_settings(3'(p), 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
         send_vector(32'h0003_0000, 32'hfffc_0000, 32'h8000_0000);
         send_vector(32'h8000_0000, 32'h7fff_ffff, 32'h0);
      end

      load_settings(PLANE_XY, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vector(32'h7fff_ffff, 32'h1, 32'h7fff_ffff);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h1000_0000);
      load_settings(PLANE_ZY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_vector(32'h0, 32'h0, 32'h0);

      for (int phase_no = 0; phase_no < 12; phase_no++) begin
         load_settings(3'(($urandom_range(0, 7) == 0) ? $urandom_range(6, 7)
                                                       : $urandom_range(0, 5)),
                       pick_gain(), pick_gain(), pick_gain(), pick_gain());
         if (phase_no == 1 || phase_no == 7) hold_requests <= hold_requests + 1;
         repeat (110) begin
            cx = pick_component();
            cy = pick_component();
            cz = pick_component();
            if ($urandom_range(0, 24) == 0) begin
               cx = 0;
               cy = 0;
               cz = 0;
            end
            send_vector(cx, cy, cz);
         end
      end

      wait_drained();
      repeat (80) @(posedge clock);
      $display("Sent %0d vectors over all six axis pairs and the invalid codes,", vectors_sent);
      $display("with %0d register writes; %0d results compared.", csr_writes, result_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
